// ===== sv/lpht_pkg.sv =====
package lpht_pkg;

	localparam int KEY_W    = 31;
	localparam int SLOT_W   = 7;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 8;
	localparam int CNT_W    = $clog2(KEY_W);

	localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 8'd101;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_PROBE,
		S_OUT
	} state_t;

endpackage

// ===== sv/lpht_ram.sv =====
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/linear_probe_hash_table_top.sv =====
// Open-addressed hash table with linear probing. Each request inserts a key
// (duplicates allowed) or deletes the first stored copy of a key, and yields
// one response with the slot used and a status. The home slot is the key modulo
// the active table size (table_size, with 0 read as 1 and values above CAPACITY
// read as CAPACITY), and probing runs upward from home to the last active slot
// without wrapping. After reset the block sweeps the key memory, marking every
// slot empty, and takes no request until that is done; configuration writes
// are taken at any time. A request is then accepted, passes through the
// bit-serial remainder unit, probes slots through the key memory's registered
// read port (one slot per cycle), and waits in the response register until
// rsp_ready takes it. One request is in the block at a time.
module linear_probe_hash_table_top #(
	parameter int CAPACITY = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  lpht_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output lpht_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [lpht_pkg::CFG_W-1:0] cfg_data
);

	import lpht_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int SW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_W + 1;
	localparam logic [AW-1:0]    LAST_ADDR = AW'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(KEY_W - 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0] table_size_q;
	logic [AW-1:0]    clr_q;
	logic             pend_s1;
	logic [AW-1:0]    addr_s1;

	logic             mode_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] dividend_q;
	logic [SW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    size_q;
	logic [AW-1:0]    home_q;
	logic [AW-1:0]    last_q;
	logic [AW-1:0]    rd_addr_q;
	rsp_t             rsp_q;

	logic [SW-1:0]    size_eff;
	logic [SW:0]      trial;
	logic [SW:0]      trial_sub;
	logic [SW-1:0]    rem_d;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic [EW-1:0]    ram_rdata;

	logic             slot_used;
	logic             hit;
	logic             probe_end;
	logic [31:0]      slot_wide;

	lpht_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_keys (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (table_size_q == '0) begin
			size_eff = SW'(1);
		end else if (32'(table_size_q) > 32'(CAPACITY)) begin
			size_eff = SW'(CAPACITY);
		end else begin
			size_eff = SW'(table_size_q);
		end
	end

	// One restoring step of key % size per cycle, most significant bit first.
	assign trial     = {rem_q, dividend_q[KEY_W-1]};
	assign trial_sub = trial - {1'b0, size_q};
	assign rem_d     = (trial >= {1'b0, size_q}) ? trial_sub[SW-1:0] : trial[SW-1:0];

	// Each memory word holds the occupancy bit above the stored key.
	assign slot_used = ram_rdata[KEY_W];
	assign hit = (mode_q == MODE_DELETE) ?
		(slot_used && (ram_rdata[KEY_W-1:0] == key_q)) : !slot_used;
	assign probe_end = pend_s1 && (hit || (addr_s1 == last_q));
	assign slot_wide = 32'(hit ? addr_s1 : home_q);

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (probe_end) begin
					state_d = S_OUT;
					if (hit) begin
						ram_we    = 1'b1;
						ram_waddr = addr_s1;
						ram_wdata = {mode_q == MODE_INSERT, key_q};
					end
				end
			end
			S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RESET;
			clr_q        <= '0;
			pend_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_size_q <= cfg_data;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			pend_s1 <= (state_q == S_PROBE) && !probe_end;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q     <= req.mode;
				key_q      <= req.key;
				dividend_q <= req.key;
				rem_q      <= '0;
				cnt_q      <= '0;
				size_q     <= size_eff;
			end
			S_DIV: begin
				rem_q      <= rem_d;
				dividend_q <= dividend_q << 1;
				cnt_q      <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					home_q    <= rem_d[AW-1:0];
					rd_addr_q <= rem_d[AW-1:0];
					last_q    <= AW'(size_q - SW'(1));
				end
			end
			S_PROBE: begin
				// Reads run one slot ahead of the check on the registered data.
				rd_addr_q <= rd_addr_q + AW'(1);
				addr_s1   <= rd_addr_q;
				if (probe_end) begin
					rsp_q.slot <= slot_wide[SLOT_W-1:0];
					if (hit) begin
						rsp_q.status <= STATUS_DONE;
					end else if (mode_q == MODE_DELETE) begin
						rsp_q.status <= STATUS_NOT_FOUND;
					end else begin
						rsp_q.status <= STATUS_FULL;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp = rsp_q;

endmodule
